### hw/rtl/cmbs_pkg.sv
// shared types, constants and checksum helpers for the multiboot rom sender
// used by cmbs_step and console_multiboot_rom_sender_top; no dependencies
package cmbs_pkg;

    localparam int unsigned MAX_IMAGE_BYTES = 262144;
    localparam int unsigned HEADER_BYTES    = 192;

    localparam int unsigned SIZE_W   = 19;
    localparam int unsigned OFFSET_W = 18;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CRC_W    = 16;

    localparam logic [SIZE_W-1:0] MIN_SIZE      = 19'd448;
    localparam logic [SIZE_W-1:0] MAX_SIZE      = SIZE_W'(MAX_IMAGE_BYTES);
    localparam logic [SIZE_W-1:0] HEADER_HALVES = SIZE_W'(HEADER_BYTES / 2);
    localparam logic [SIZE_W-1:0] HEADER_END    = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] SIZE_BIAS     = 19'h190;

    // link command words
    localparam logic [31:0] CMD_POLL      = 32'h0000_6202;
    localparam logic [15:0] RSP_PRESENT   = 16'h7202;
    localparam logic [31:0] CMD_HDR_START = 32'h0000_6102;
    localparam logic [31:0] CMD_HDR_END   = 32'h0000_6200;
    localparam logic [31:0] CMD_PALETTE   = 32'h0000_63D1;
    localparam logic [7:0]  RSP_KEY_TAG   = 8'h73;
    localparam logic [7:0]  CMD_SEED_HI   = 8'h64;
    localparam logic [31:0] CMD_FINISH    = 32'h0000_0065;
    localparam logic [15:0] RSP_CRC_READY = 16'h0075;
    localparam logic [31:0] CMD_CRC       = 32'h0000_0066;
    localparam logic [31:0] RSP_RUNNING   = 32'h0000_0200;

    localparam logic [15:0] KEY_BASE_HI  = 16'hFFFF;
    localparam logic [7:0]  KEY_BASE_LO  = 8'hD1;
    localparam logic [7:0]  SEED_ADJUST  = 8'h0F;
    localparam logic [31:0] KEY_MULT     = 32'h6F64_6573;
    localparam logic [31:0] POS_BASE     = 32'hFE00_0000;
    localparam logic [31:0] DATA_MASK    = 32'h4320_2F2F;
    localparam logic [15:0] CRC_POLY     = 16'hC37B;
    localparam logic [15:0] CRC_INIT     = 16'hC387;
    localparam logic [15:0] FIN_WORD_HI  = 16'hFFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE     = 3'd0,
        ST_BUSY     = 3'd1,
        ST_DONE     = 3'd2,
        ST_RUNNING  = 3'd3,
        ST_HS_FAIL  = 3'd4,
        ST_ECHO_BAD = 3'd5
    } status_t;

    typedef enum logic [13:0] {
        PH_IDLE    = 14'b00_0000_0000_0001,
        PH_POLL    = 14'b00_0000_0000_0010,
        PH_HEADER  = 14'b00_0000_0000_0100,
        PH_ENDHDR  = 14'b00_0000_0000_1000,
        PH_SYNC    = 14'b00_0000_0001_0000,
        PH_KEY1    = 14'b00_0000_0010_0000,
        PH_KEY2    = 14'b00_0000_0100_0000,
        PH_SEEDACK = 14'b00_0000_1000_0000,
        PH_SIZE    = 14'b00_0001_0000_0000,
        PH_DATA    = 14'b00_0010_0000_0000,
        PH_FIN1    = 14'b00_0100_0000_0000,
        PH_POLLCRC = 14'b00_1000_0000_0000,
        PH_CRCCMD  = 14'b01_0000_0000_0000,
        PH_CRCSENT = 14'b10_0000_0000_0000
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [SIZE_W-1:0]  position;
        logic [31:0]        key_seed;
        logic [CRC_W-1:0]   running_crc;
        logic [7:0]         seed_adj;
        logic [7:0]         target_seed;
        logic [SIZE_W-1:0]  padded_size;
        status_t            final_status;
        logic [CRC_W-1:0]   target_crc;
    } cmbs_state_t;

    typedef struct packed {
        logic        op;
        logic [31:0] rx_word;
        logic [31:0] rom_word;
    } cmbs_item_t;

    typedef struct packed {
        logic                send;
        logic [31:0]         tx_word;
        logic [OFFSET_W-1:0] rom_offset;
        status_t             status;
        logic [CRC_W-1:0]    computed_crc;
        logic [CRC_W-1:0]    target_crc;
    } cmbs_result_t;

    // one output bit of the word checksum as a mask over {word, crc}
    typedef logic [CRC_W-1:0][47:0] crc_mat_t;

    // bit-serial reference, evaluated only at elaboration
    function automatic logic [CRC_W-1:0] crc_serial(logic [CRC_W-1:0] c, logic [31:0] w);
        logic [CRC_W-1:0] r;
        logic [31:0]      d;
        r = c;
        d = w;
        for (int b = 0; b < 32; b++)
        begin
            r = (r >> 1) ^ (((r[0] ^ d[0]) == 1'b1) ? CRC_POLY : 16'h0000);
            d = d >> 1;
        end
        return r;
    endfunction

    function automatic crc_mat_t crc_matrix();
        crc_mat_t    m;
        logic [47:0] v;
        logic [15:0] r;
        m = '0;
        for (int j = 0; j < 48; j++)
        begin
            v = 48'd1 << j;
            r = crc_serial(v[15:0], v[47:16]);
            for (int i = 0; i < CRC_W; i++)
            begin
                m[i][j] = r[i];
            end
        end
        return m;
    endfunction

    localparam crc_mat_t CRC_MAT = crc_matrix();

    // parallel form: each bit is an xor over a fixed set of inputs
    function automatic logic [CRC_W-1:0] crc_apply(logic [CRC_W-1:0] c, logic [31:0] w);
        logic [CRC_W-1:0] r;
        logic [47:0]      v;
        v = {w, c};
        for (int i = 0; i < CRC_W; i++)
        begin
            r[i] = ^(CRC_MAT[i] & v);
        end
        return r;
    endfunction

endpackage

### hw/rtl/console_multiboot_rom_sender_top.sv
// top level of the multiboot rom sender: input register, session state, result register
// depends on cmbs_pkg and cmbs_step
//
// channel   dir  handshake          contents
// s_*       in   tvalid/tready      one link response or a start command
// m_*       out  tvalid/tready      one word to exchange plus status and checksums
// cfg_*     in   write enable only  image length in bytes
//
// one item is taken every clock unless m_tready stalls the result; its result passes
// through the input register and then the result register around the step logic
// the step logic holds one 32x32 multiply and a parallel xor checksum update
// rst_n clears the session to idle and the image length to its maximum
// a stalled result holds while the input register keeps one more item
module console_multiboot_rom_sender_top #(
    parameter int unsigned MAX_IMAGE_BYTES = cmbs_pkg::MAX_IMAGE_BYTES,
    parameter int unsigned HEADER_BYTES    = cmbs_pkg::HEADER_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // rx_word[31:0], rom_word[63:32]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // tx_word[31:0], rom_offset[49:32], status[52:50],
                                   // computed_crc[68:53], target_crc[84:69], zero pad
    output logic        m_tuser,   // send
    input  logic        cfg_we,
    input  logic [18:0] cfg_data   // rom_size
);

    localparam logic [cmbs_pkg::SIZE_W-1:0] SIZE_RESET = MAX_IMAGE_BYTES[cmbs_pkg::SIZE_W-1:0];

    logic                        in_valid_reg;
    cmbs_pkg::cmbs_item_t        item_reg;
    logic                        out_valid_reg;
    cmbs_pkg::cmbs_result_t      res_reg;
    cmbs_pkg::cmbs_result_t      res_next;
    cmbs_pkg::cmbs_state_t       state_reg;
    cmbs_pkg::cmbs_state_t       state_next;
    logic [cmbs_pkg::SIZE_W-1:0] rom_size_reg;
    logic                        advance;
    logic                        s_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    cmbs_step #(
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES),
        .HEADER_BYTES    (HEADER_BYTES)
    ) u_step (
        .state      (state_reg),
        .item       (item_reg),
        .rom_size   (rom_size_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rom_size_reg  <= SIZE_RESET;
            state_reg     <= '{phase: cmbs_pkg::PH_IDLE, final_status: cmbs_pkg::ST_IDLE,
                               default: '0};
        end
        else
        begin
            if (cfg_we)
            begin
                rom_size_reg <= cfg_data;
            end
            if (s_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            item_reg <= '{op: s_tuser, rx_word: s_tdata[31:0], rom_word: s_tdata[63:32]};
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.send;
    assign m_tdata  = {3'd0, res_reg.target_crc, res_reg.computed_crc, res_reg.status,
                       res_reg.rom_offset, res_reg.tx_word};

endmodule

### hw/rtl/cmbs_step.sv
// next-state and result logic for one link exchange of the rom sender
// depends on cmbs_pkg (state, item and result types, checksum function)
module cmbs_step #(
    parameter int unsigned MAX_IMAGE_BYTES = cmbs_pkg::MAX_IMAGE_BYTES,
    parameter int unsigned HEADER_BYTES    = cmbs_pkg::HEADER_BYTES
) (
    input  cmbs_pkg::cmbs_state_t          state,
    input  cmbs_pkg::cmbs_item_t           item,
    input  logic [cmbs_pkg::SIZE_W-1:0]    rom_size,
    output cmbs_pkg::cmbs_state_t          state_next,
    output cmbs_pkg::cmbs_result_t         result
);

    localparam int unsigned                HALVES_INT    = HEADER_BYTES / 2;
    localparam logic [cmbs_pkg::SIZE_W-1:0] MAX_SIZE      =
        MAX_IMAGE_BYTES[cmbs_pkg::SIZE_W-1:0];
    localparam logic [cmbs_pkg::SIZE_W-1:0] HEADER_HALVES = HALVES_INT[cmbs_pkg::SIZE_W-1:0];
    localparam logic [cmbs_pkg::SIZE_W-1:0] HEADER_END    = HEADER_BYTES[cmbs_pkg::SIZE_W-1:0];

    logic [cmbs_pkg::SIZE_W-1:0]   size_clamped;
    logic [cmbs_pkg::SIZE_W-1:0]   size_rounded;
    logic [cmbs_pkg::SIZE_W-1:0]   size_final;
    logic [cmbs_pkg::SIZE_W-1:0]   pos_inc;
    logic [cmbs_pkg::SIZE_W-1:0]   pos_plus4;
    logic [cmbs_pkg::SIZE_W-1:0]   pos_data;
    logic [cmbs_pkg::SIZE_W-1:0]   pos_data_plus4;
    logic [cmbs_pkg::SIZE_W-1:0]   size_diff;
    logic [31:0]                   key_mult;
    logic [31:0]                   data_tx;
    logic [cmbs_pkg::OFFSET_W-1:0] data_off;
    logic [cmbs_pkg::CRC_W-1:0]    crc_c;
    logic [31:0]                   crc_w;
    logic [cmbs_pkg::CRC_W-1:0]    crc_out;
    logic                          send;
    logic [31:0]                   tx;
    logic [cmbs_pkg::OFFSET_W-1:0] off;
    cmbs_pkg::status_t             st;

    // image size, clamped and rounded up to 16 (down by 16 if that passes the maximum)
    always_comb
    begin
        size_clamped = rom_size;
        if (rom_size < cmbs_pkg::MIN_SIZE)
        begin
            size_clamped = cmbs_pkg::MIN_SIZE;
        end
        else if (rom_size > MAX_SIZE)
        begin
            size_clamped = MAX_SIZE;
        end
        size_rounded = (size_clamped + 19'd15) & ~19'd15;
        size_final   = (size_rounded > MAX_SIZE) ? size_rounded - 19'd16
                                                 : size_rounded;
    end

    assign pos_inc   = state.position + 19'd1;
    assign pos_plus4 = state.position + 19'd4;
    assign size_diff = state.padded_size - cmbs_pkg::SIZE_BIAS;

    // encrypted data word: first word at the header end, then each next word
    assign pos_data       = state.phase == cmbs_pkg::PH_SIZE ? HEADER_END
                                                             : pos_plus4;
    assign pos_data_plus4 = pos_data + 19'd4;
    assign key_mult       = state.key_seed * cmbs_pkg::KEY_MULT + 32'd1;
    assign data_tx        = key_mult ^ item.rom_word
                          ^ (cmbs_pkg::POS_BASE - {13'd0, pos_data}) ^ cmbs_pkg::DATA_MASK;
    assign data_off       = (pos_data_plus4 < state.padded_size) ? pos_data_plus4[17:0]
                                                                 : 18'd0;

    // shared checksum unit: data words, or the closing seed word
    always_comb
    begin
        if (state.phase == cmbs_pkg::PH_SIZE)
        begin
            crc_c = cmbs_pkg::CRC_INIT;
            crc_w = item.rom_word;
        end
        else if (state.phase == cmbs_pkg::PH_DATA && !(pos_plus4 < state.padded_size))
        begin
            crc_c = state.running_crc;
            crc_w = {cmbs_pkg::FIN_WORD_HI, state.target_seed, state.seed_adj};
        end
        else
        begin
            crc_c = state.running_crc;
            crc_w = item.rom_word;
        end
    end

    assign crc_out = cmbs_pkg::crc_apply(crc_c, crc_w);

    always_comb
    begin
        state_next = state;
        send       = 1'b1;
        tx         = 32'd0;
        off        = 18'd0;
        if (item.op == 1'b0)
        begin
            state_next.padded_size  = size_final;
            state_next.position     = '0;
            state_next.key_seed     = '0;
            state_next.running_crc  = '0;
            state_next.seed_adj     = '0;
            state_next.target_seed  = '0;
            state_next.target_crc   = '0;
            state_next.final_status = cmbs_pkg::ST_IDLE;
            state_next.phase        = cmbs_pkg::PH_POLL;
            tx                      = cmbs_pkg::CMD_POLL;
        end
        else
        begin
            case (state.phase)
                cmbs_pkg::PH_POLL:
                begin
                    if (item.rx_word == cmbs_pkg::RSP_RUNNING)
                    begin
                        state_next.phase        = cmbs_pkg::PH_IDLE;
                        state_next.final_status = cmbs_pkg::ST_RUNNING;
                        send                    = 1'b0;
                    end
                    else if (item.rx_word[31:16] == cmbs_pkg::RSP_PRESENT)
                    begin
                        state_next.phase    = cmbs_pkg::PH_HEADER;
                        state_next.position = '0;
                        tx                  = cmbs_pkg::CMD_HDR_START;
                    end
                    else
                    begin
                        tx = cmbs_pkg::CMD_POLL;
                    end
                end
                cmbs_pkg::PH_HEADER:
                begin
                    if (state.position < HEADER_HALVES)
                    begin
                        tx = state.position[0] ? {16'd0, item.rom_word[31:16]}
                                               : {16'd0, item.rom_word[15:0]};
                        state_next.position = pos_inc;
                        if (pos_inc < HEADER_HALVES)
                        begin
                            off = {pos_inc[16:0], 1'b0} & ~18'd3;
                        end
                    end
                    else
                    begin
                        tx               = cmbs_pkg::CMD_HDR_END;
                        state_next.phase = cmbs_pkg::PH_ENDHDR;
                    end
                end
                cmbs_pkg::PH_ENDHDR:
                begin
                    tx               = cmbs_pkg::CMD_POLL;
                    state_next.phase = cmbs_pkg::PH_SYNC;
                end
                cmbs_pkg::PH_SYNC:
                begin
                    tx               = cmbs_pkg::CMD_PALETTE;
                    state_next.phase = cmbs_pkg::PH_KEY1;
                end
                cmbs_pkg::PH_KEY1:
                begin
                    tx               = cmbs_pkg::CMD_PALETTE;
                    state_next.phase = cmbs_pkg::PH_KEY2;
                end
                cmbs_pkg::PH_KEY2:
                begin
                    if (item.rx_word[31:24] != cmbs_pkg::RSP_KEY_TAG)
                    begin
                        state_next.phase        = cmbs_pkg::PH_IDLE;
                        state_next.final_status = cmbs_pkg::ST_HS_FAIL;
                        send                    = 1'b0;
                    end
                    else
                    begin
                        state_next.key_seed = {cmbs_pkg::KEY_BASE_HI, item.rx_word[23:16],
                                               cmbs_pkg::KEY_BASE_LO};
                        state_next.seed_adj = item.rx_word[23:16] + cmbs_pkg::SEED_ADJUST;
                        tx = {16'd0, cmbs_pkg::CMD_SEED_HI,
                              item.rx_word[23:16] + cmbs_pkg::SEED_ADJUST};
                        state_next.phase = cmbs_pkg::PH_SEEDACK;
                    end
                end
                cmbs_pkg::PH_SEEDACK:
                begin
                    tx               = {15'd0, size_diff[18:2]};
                    off              = HEADER_END[17:0];
                    state_next.phase = cmbs_pkg::PH_SIZE;
                end
                cmbs_pkg::PH_SIZE:
                begin
                    state_next.target_seed = item.rx_word[23:16];
                    state_next.running_crc = crc_out;
                    state_next.position    = HEADER_END;
                    state_next.key_seed    = key_mult;
                    tx                     = data_tx;
                    off                    = data_off;
                    state_next.phase       = cmbs_pkg::PH_DATA;
                end
                cmbs_pkg::PH_DATA:
                begin
                    if (item.rx_word[31:16] != state.position[15:0])
                    begin
                        state_next.phase        = cmbs_pkg::PH_IDLE;
                        state_next.final_status = cmbs_pkg::ST_ECHO_BAD;
                        send                    = 1'b0;
                    end
                    else if (pos_plus4 < state.padded_size)
                    begin
                        state_next.position    = pos_plus4;
                        state_next.running_crc = crc_out;
                        state_next.key_seed    = key_mult;
                        tx                     = data_tx;
                        off                    = data_off;
                    end
                    else
                    begin
                        state_next.running_crc = crc_out;
                        tx                     = cmbs_pkg::CMD_FINISH;
                        state_next.phase       = cmbs_pkg::PH_FIN1;
                    end
                end
                cmbs_pkg::PH_FIN1:
                begin
                    tx               = cmbs_pkg::CMD_FINISH;
                    state_next.phase = cmbs_pkg::PH_POLLCRC;
                end
                cmbs_pkg::PH_POLLCRC:
                begin
                    if (item.rx_word[31:16] == cmbs_pkg::RSP_CRC_READY)
                    begin
                        tx               = cmbs_pkg::CMD_CRC;
                        state_next.phase = cmbs_pkg::PH_CRCCMD;
                    end
                    else
                    begin
                        tx = cmbs_pkg::CMD_FINISH;
                    end
                end
                cmbs_pkg::PH_CRCCMD:
                begin
                    tx               = {16'd0, state.running_crc};
                    state_next.phase = cmbs_pkg::PH_CRCSENT;
                end
                cmbs_pkg::PH_CRCSENT:
                begin
                    state_next.target_crc   = item.rx_word[31:16];
                    state_next.phase        = cmbs_pkg::PH_IDLE;
                    state_next.final_status = cmbs_pkg::ST_DONE;
                    send                    = 1'b0;
                end
                default:
                begin
                    send = 1'b0;
                end
            endcase
        end
    end

    assign st = (state_next.phase == cmbs_pkg::PH_IDLE) ? state_next.final_status
                                                        : cmbs_pkg::ST_BUSY;

    always_comb
    begin
        result.send         = send;
        result.tx_word      = send ? tx : 32'd0;
        result.rom_offset   = send ? off : 18'd0;
        result.status       = st;
        result.computed_crc = (st == cmbs_pkg::ST_DONE) ? state_next.running_crc : 16'd0;
        result.target_crc   = (st == cmbs_pkg::ST_DONE) ? state_next.target_crc : 16'd0;
    end

endmodule
